>>> rtl/mmof_pkg.sv
`default_nettype none

package mmof_pkg;

    // window depth and field widths
    localparam int WINDOW   = 4;
    localparam int SAMPLE_W = 16;
    localparam int MAXDEV_W = 16;

    // running sum holds WINDOW samples without overflow
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
    // WINDOW*x - sum and WINDOW*max_deviation both fit here
    localparam int DIFF_W = SUM_W + 2;
    // fill counter saturates at WINDOW
    localparam int FILL_W = $clog2(WINDOW + 1);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic signed [DIFF_W-1:0]   diff_t;
    typedef logic [FILL_W-1:0]          fill_t;

    // per-cell control from the window controller
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/mmof_if.sv
`default_nettype none

// sample channel into the filter
interface mmof_in_if;
    logic              valid;
    logic              ready;
    mmof_pkg::sample_t sample;
    logic              restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

// result channel out of the filter
interface mmof_out_if;
    logic              valid;
    logic              ready;
    mmof_pkg::sample_t kept_sample;
    logic              was_checked;

    modport source (output valid, output kept_sample, output was_checked, input ready);
    modport sink   (input valid, input kept_sample, input was_checked, output ready);
endinterface

`default_nettype wire

>>> rtl/mmof_cell.sv
`default_nettype none

// one window slot: on a shift, loads its neighbor's value, or zero if clear is also set
module mmof_cell
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mmof_pkg::cell_ctrl_t ctrl,
    input  wire mmof_pkg::sample_t    d_in,
    output mmof_pkg::sample_t         q
);

    mmof_pkg::sample_t value_reg;
    mmof_pkg::sample_t value_next;

    // next slot value
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.shift)
        begin
            value_next = ctrl.clear ? '0 : d_in;
        end
    end

    // slot storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign q = value_reg;

endmodule

`default_nettype wire

>>> rtl/moving_mean_outlier_filter_core.sv
`default_nettype none

// Moving-mean outlier filter. Keeps a row of WINDOW cells holding the last
// accepted samples, plus their running sum. The first WINDOW samples of a set
// pass unchecked (was_checked = 0); after that a sample passes only if
// |WINDOW*sample - sum| <= WINDOW*max_deviation; a rejected sample produces no
// result and leaves the window unchanged. restart clears the window before its
// own sample is handled. A passing sample appears on the result channel in the
// cycle after its transfer; the single output register lets a new sample
// transfer in the same cycle as the held result transfers out, so it takes one
// sample per clock unless out_ch stalls. The user must write max_deviation
// through cfg_we/cfg_wdata only while no sample is in flight; not enforced.
module moving_mean_outlier_filter_core
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    mmof_in_if.sink                               in_ch,
    mmof_out_if.source                            out_ch,
    input  wire logic                             cfg_we,
    input  wire logic [mmof_pkg::MAXDEV_W-1:0]    cfg_wdata
);

    localparam int W = mmof_pkg::WINDOW;

    // configuration register
    logic [mmof_pkg::MAXDEV_W-1:0] max_dev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dev_reg <= '0;
        end
        else if (cfg_we)
        begin
            max_dev_reg <= cfg_wdata;
        end
    end

    // window state
    mmof_pkg::sum_t  sum_reg;
    mmof_pkg::sum_t  sum_next;
    mmof_pkg::fill_t fill_reg;
    mmof_pkg::fill_t fill_next;

    // output register
    logic              out_valid_reg;
    logic              out_valid_next;
    mmof_pkg::sample_t kept_reg;
    logic              checked_reg;

    // cell row signals
    mmof_pkg::sample_t    cell_q   [W];
    mmof_pkg::sample_t    cell_d   [W];
    mmof_pkg::cell_ctrl_t cell_ctl [W];

    logic              in_ready_w;
    logic              in_xfer;
    logic              pass;
    logic              full;
    mmof_pkg::sum_t    sum_eff;
    mmof_pkg::fill_t   fill_eff;
    mmof_pkg::sample_t oldest_eff;
    mmof_pkg::diff_t   x_ext;
    mmof_pkg::diff_t   sum_ext;
    mmof_pkg::diff_t   diff;
    logic [mmof_pkg::DIFF_W-1:0] abs_diff;
    logic [mmof_pkg::DIFF_W-1:0] limit;

    // input transfer whenever the output slot is free or draining
    assign in_ready_w  = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = in_ready_w;
    assign in_xfer     = in_ch.valid && in_ready_w;

    // restart clears the view of the window before the check
    assign sum_eff    = in_ch.restart ? '0 : sum_reg;
    assign fill_eff   = in_ch.restart ? '0 : fill_reg;
    assign oldest_eff = in_ch.restart ? '0 : cell_q[0];
    assign full       = (fill_eff >= mmof_pkg::FILL_W'(W));

    // distance check at wide width
    assign x_ext   = mmof_pkg::DIFF_W'(in_ch.sample);
    assign sum_ext = mmof_pkg::DIFF_W'(sum_eff);
    assign diff    = x_ext * $signed(mmof_pkg::DIFF_W'(W)) - sum_ext;
    assign abs_diff = diff[mmof_pkg::DIFF_W-1] ? mmof_pkg::DIFF_W'(-diff)
                                               : mmof_pkg::DIFF_W'(diff);
    assign limit   = mmof_pkg::DIFF_W'(max_dev_reg) * mmof_pkg::DIFF_W'(W);

    assign pass = in_xfer && (!full || (abs_diff <= limit));

    // state update on a passing sample
    always_comb
    begin
        sum_next  = sum_reg;
        fill_next = fill_reg;
        if (pass)
        begin
            sum_next  = sum_eff - mmof_pkg::SUM_W'(oldest_eff)
                        + mmof_pkg::SUM_W'(in_ch.sample);
            fill_next = full ? fill_eff : fill_eff + mmof_pkg::FILL_W'(1);
        end
    end

    // output slot valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pass)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (pass)
        begin
            kept_reg    <= in_ch.sample;
            checked_reg <= full;
        end
    end

    // row of window cells, oldest at index 0, new sample enters at the top
    for (genvar i = 0; i < W; i++)
    begin : g_cell
        if (i == W - 1)
        begin : g_last
            assign cell_d[i]   = in_ch.sample;
            assign cell_ctl[i] = '{shift: pass, clear: 1'b0};
        end
        else
        begin : g_mid
            assign cell_d[i]   = cell_q[i+1];
            assign cell_ctl[i] = '{shift: pass, clear: in_ch.restart};
        end

        mmof_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (cell_ctl[i]),
            .d_in  (cell_d[i]),
            .q     (cell_q[i])
        );
    end

    // result channel
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.kept_sample = kept_reg;
    assign out_ch.was_checked = checked_reg;

endmodule

`default_nettype wire
